// ===== hw/rtl/quadratic_root_solver_top_macros.svh =====
// Assertion macros used by the checker file of the root solver.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef QUADRATIC_ROOT_SOLVER_TOP_MACROS_SVH
`define QUADRATIC_ROOT_SOLVER_TOP_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define QRS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("root solver check failed");

// Next-cycle implication, ignored while reset is high.
`define QRS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("root solver check failed");

// Condition that must hold in the cycle after reset is seen.
`define QRS_ASSERT_RST(lbl, cons) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("root solver reset check failed");

`endif

// ===== hw/rtl/qrs_pkg.sv =====
`default_nettype none

package qrs_pkg;

  // Default number of fractional bits of the fixed-point format.
  localparam int FRAC_BITS_DEF = 16;

  // Fixed widths that follow from the 32-bit coefficient fields.
  localparam int COEF_W    = 32;
  localparam int PROD_W    = 64;
  localparam int DISC_W    = 66;
  localparam int ROOT_W    = DISC_W / 2;
  localparam int NUM_MAG_W = 34;
  localparam int DEN_W     = 33;

  // Kind of solution reported with each result.
  typedef enum logic [2:0] {
    CASE_ALL     = 3'd0,
    CASE_NONE    = 3'd1,
    CASE_LINEAR  = 3'd2,
    CASE_TWO     = 3'd3,
    CASE_DOUBLE  = 3'd4,
    CASE_COMPLEX = 3'd5
  } case_code_t;

  // Coefficient summary carried alongside the square root pipeline.
  typedef struct packed {
    case_code_t          code;
    logic                a_neg;
    logic                b_neg;
    logic                c_neg;
    logic                b_zero;
    logic                c_zero;
    logic [COEF_W-1:0]   ma;
    logic [COEF_W-1:0]   mb;
    logic [COEF_W-1:0]   mc;
  } side_t;

  // Control carried alongside the divider pipeline.
  typedef struct packed {
    case_code_t code;
    logic       neg1;
    logic       neg2;
  } div_side_t;

  // One saturated result value.
  typedef struct packed {
    logic              sat;
    logic [COEF_W-1:0] val;
  } fix_t;

endpackage

`default_nettype wire

// ===== hw/rtl/qrs_sqrt.sv =====
`default_nettype none

// Pipelined integer square root, one root bit resolved per stage.
module qrs_sqrt #(
  parameter int IN_W   = 66,
  parameter int SIDE_W = 1
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                en,
  input  wire logic                in_valid,
  input  wire logic [IN_W-1:0]     in_value,
  input  wire logic [SIDE_W-1:0]   in_side,
  output logic                     out_valid,
  output logic [IN_W/2-1:0]        out_root,
  output logic [SIDE_W-1:0]        out_side
);

  localparam int RTW    = IN_W / 2;
  localparam int RW     = RTW + 3;
  localparam int STAGES = RTW;

  logic              vld  [STAGES+1];
  logic [IN_W-1:0]   val  [STAGES+1];
  logic [RW-1:0]     rem  [STAGES+1];
  logic [RTW-1:0]    root [STAGES+1];
  logic [SIDE_W-1:0] side [STAGES+1];

  // Stage zero is the incoming beat with an empty remainder and root.
  assign vld[0]  = in_valid;
  assign val[0]  = in_value;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign side[0] = in_side;

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    logic [RW-1:0] rsh;
    logic [RW-1:0] trial;
    logic          take;

    // Bring down the next two radicand bits and try the next root bit.
    assign rsh   = {rem[k][RW-3:0], val[k][IN_W-1 -: 2]};
    assign trial = {{(RW-RTW-2){1'b0}}, root[k], 2'b01};
    assign take  = (rsh >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        val[k+1]  <= {val[k][IN_W-3:0], 2'b00};
        rem[k+1]  <= take ? (rsh - trial) : rsh;
        root[k+1] <= {root[k][RTW-2:0], take};
        side[k+1] <= side[k];
      end
    end
  end

  assign out_valid = vld[STAGES];
  assign out_root  = root[STAGES];
  assign out_side  = side[STAGES];

endmodule

`default_nettype wire

// ===== hw/rtl/qrs_div.sv =====
`default_nettype none

// Two-lane pipelined restoring divider sharing one divisor, one quotient
// bit per lane and stage.
module qrs_div #(
  parameter int NUM_W  = 50,
  parameter int DEN_W  = 33,
  parameter int SIDE_W = 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  en,
  input  wire logic                  in_valid,
  input  wire logic [1:0][NUM_W-1:0] in_dividend,
  input  wire logic [DEN_W-1:0]      in_divisor,
  input  wire logic [SIDE_W-1:0]     in_side,
  output logic                       out_valid,
  output logic [1:0][NUM_W-1:0]      out_quotient,
  output logic [SIDE_W-1:0]          out_side
);

  localparam int STAGES = NUM_W;
  localparam int LANES  = 2;

  logic                  vld  [STAGES+1];
  logic [1:0][NUM_W-1:0] nq   [STAGES+1];
  logic [1:0][DEN_W-1:0] rem  [STAGES+1];
  logic [DEN_W-1:0]      den  [STAGES+1];
  logic [SIDE_W-1:0]     side [STAGES+1];

  // Each lane shifts dividend bits out the top and quotient bits in below.
  assign vld[0]  = in_valid;
  assign nq[0]   = in_dividend;
  assign rem[0]  = '0;
  assign den[0]  = in_divisor;
  assign side[0] = in_side;

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    logic [1:0][DEN_W-1:0] rem_next;
    logic [1:0][NUM_W-1:0] nq_next;

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [DEN_W:0] rsh;
      logic [DEN_W:0] diff;
      logic           take;

      assign rsh         = {rem[k][l], nq[k][l][NUM_W-1]};
      assign diff        = rsh - {1'b0, den[k]};
      assign take        = (rsh >= {1'b0, den[k]});
      assign rem_next[l] = take ? diff[DEN_W-1:0] : rsh[DEN_W-1:0];
      assign nq_next[l]  = {nq[k][l][NUM_W-2:0], take};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nq[k+1]   <= nq_next;
        rem[k+1]  <= rem_next;
        den[k+1]  <= den[k];
        side[k+1] <= side[k];
      end
    end
  end

  assign out_valid    = vld[STAGES];
  assign out_quotient = nq[STAGES];
  assign out_side     = side[STAGES];

endmodule

`default_nettype wire

// ===== hw/rtl/quadratic_root_solver_top.sv =====
`default_nettype none

// Quadratic equation solver for signed fixed-point coefficients a, b, c with
// FRAC_BITS fractional bits. Each coefficient beat yields one result beat: a
// case code (all reals, none, linear, two real, double, complex pair), two
// saturated values and a saturation flag. The block is fully pipelined and
// takes a new beat every cycle while the result side keeps up. The pipeline
// is made of three front stages (input, multipliers, discriminant), the
// 33-stage square root that resolves one root bit per stage, one operand
// select stage, the divider that resolves one quotient bit per stage over
// 34 + FRAC_BITS stages, and the output register. A one-beat skid buffer
// behind the pipeline lets coef_ready stay high while a finished result
// waits on result_ready.
module quadratic_root_solver_top #(
  parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        coef_valid,
  output logic             coef_ready,
  input  wire logic signed [31:0] coef_square,
  input  wire logic signed [31:0] coef_linear,
  input  wire logic signed [31:0] coef_constant,
  output logic             result_valid,
  input  wire logic        result_ready,
  output logic [2:0]       case_code,
  output logic signed [31:0] first_value,
  output logic signed [31:0] second_value,
  output logic             saturated
);

  localparam int CW     = qrs_pkg::COEF_W;
  localparam int NUM_W  = qrs_pkg::NUM_MAG_W + FRAC_BITS;
  localparam int DEN_W  = qrs_pkg::DEN_W;
  localparam int RTW    = qrs_pkg::ROOT_W;
  localparam int DW     = qrs_pkg::DISC_W;
  localparam int NMW    = qrs_pkg::NUM_MAG_W;

  logic en;

  // The pipeline advances whenever the skid buffer is empty.
  logic skid_valid;
  assign en         = !skid_valid;
  assign coef_ready = en;

  // Stage 1: input register.
  logic          s1_valid;
  logic [CW-1:0] s1_a, s1_b, s1_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= coef_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && coef_valid) begin
      s1_a <= coef_square;
      s1_b <= coef_linear;
      s1_c <= coef_constant;
    end
  end

  // Stage 2: magnitudes and the two products b*b and a*c.
  logic [CW-1:0] ma, mb, mc;
  assign ma = s1_a[CW-1] ? (CW'(0) - s1_a) : s1_a;
  assign mb = s1_b[CW-1] ? (CW'(0) - s1_b) : s1_b;
  assign mc = s1_c[CW-1] ? (CW'(0) - s1_c) : s1_c;

  logic                      s2_valid;
  logic [qrs_pkg::PROD_W-1:0] s2_bb, s2_ac;
  logic                      s2_a_neg, s2_b_neg, s2_c_neg;
  logic                      s2_a_zero, s2_b_zero, s2_c_zero;
  logic [CW-1:0]             s2_ma, s2_mb, s2_mc;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_bb     <= mb * mb;
      s2_ac     <= ma * mc;
      s2_a_neg  <= s1_a[CW-1];
      s2_b_neg  <= s1_b[CW-1];
      s2_c_neg  <= s1_c[CW-1];
      s2_a_zero <= (s1_a == '0);
      s2_b_zero <= (s1_b == '0);
      s2_c_zero <= (s1_c == '0);
      s2_ma     <= ma;
      s2_mb     <= mb;
      s2_mc     <= mc;
    end
  end

  // Stage 3: discriminant magnitude, its sign, and the case code.
  logic [DW-1:0]       bb_ext, fac, disc;
  logic                ac_neg, d_neg;
  qrs_pkg::case_code_t code3;
  qrs_pkg::side_t      side3;

  always_comb begin
    bb_ext = {2'b00, s2_bb};
    fac    = {s2_ac, 2'b00};
    ac_neg = (s2_a_neg != s2_c_neg) && !s2_c_zero;
    d_neg  = !ac_neg && (bb_ext < fac);
    if (ac_neg) begin
      disc = bb_ext + fac;
    end else if (d_neg) begin
      disc = fac - bb_ext;
    end else begin
      disc = bb_ext - fac;
    end
    if (s2_a_zero) begin
      if (s2_b_zero) begin
        code3 = s2_c_zero ? qrs_pkg::CASE_ALL : qrs_pkg::CASE_NONE;
      end else begin
        code3 = qrs_pkg::CASE_LINEAR;
      end
    end else if (d_neg) begin
      code3 = qrs_pkg::CASE_COMPLEX;
    end else if (disc == '0) begin
      code3 = qrs_pkg::CASE_DOUBLE;
    end else begin
      code3 = qrs_pkg::CASE_TWO;
    end
    side3.code   = code3;
    side3.a_neg  = s2_a_neg;
    side3.b_neg  = s2_b_neg;
    side3.c_neg  = s2_c_neg;
    side3.b_zero = s2_b_zero;
    side3.c_zero = s2_c_zero;
    side3.ma     = s2_ma;
    side3.mb     = s2_mb;
    side3.mc     = s2_mc;
  end

  logic           s3_valid;
  logic [DW-1:0]  s3_disc;
  qrs_pkg::side_t s3_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_disc <= disc;
      s3_side <= side3;
    end
  end

  // Square root of the discriminant magnitude.
  logic           sq_valid;
  logic [RTW-1:0] sq_root;
  qrs_pkg::side_t sq_side;

  qrs_sqrt #(
    .IN_W   (DW),
    .SIDE_W ($bits(qrs_pkg::side_t))
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s3_valid),
    .in_value  (s3_disc),
    .in_side   (s3_side),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // Stage 4: numerators, shared divisor and result signs per case.
  logic [NMW:0]         b_sgn, n1, n2, n1_mag, n2_mag;
  logic [NMW-1:0]       num1, num2;
  logic [DEN_W-1:0]     den4;
  qrs_pkg::div_side_t   dside4;

  always_comb begin
    b_sgn  = sq_side.b_neg ? ((NMW+1)'(0) - {3'b000, sq_side.mb}) : {3'b000, sq_side.mb};
    n1     = {2'b00, sq_root} - b_sgn;
    n2     = (NMW+1)'(0) - b_sgn - {2'b00, sq_root};
    n1_mag = n1[NMW] ? ((NMW+1)'(0) - n1) : n1;
    n2_mag = n2[NMW] ? ((NMW+1)'(0) - n2) : n2;
    num1        = '0;
    num2        = '0;
    den4        = {sq_side.ma, 1'b0};
    dside4.code = sq_side.code;
    dside4.neg1 = 1'b0;
    dside4.neg2 = 1'b0;
    case (sq_side.code) inside
      qrs_pkg::CASE_LINEAR: begin
        num1        = {2'b00, sq_side.mc};
        den4        = {1'b0, sq_side.mb};
        dside4.neg1 = !sq_side.c_zero && (sq_side.c_neg == sq_side.b_neg);
      end
      qrs_pkg::CASE_DOUBLE, qrs_pkg::CASE_COMPLEX: begin
        num1        = {2'b00, sq_side.mb};
        num2        = {1'b0, sq_root};
        dside4.neg1 = !sq_side.b_zero && (sq_side.b_neg == sq_side.a_neg);
        dside4.neg2 = sq_side.a_neg && (sq_root != '0);
      end
      qrs_pkg::CASE_TWO: begin
        num1        = n1_mag[NMW-1:0];
        num2        = n2_mag[NMW-1:0];
        dside4.neg1 = (n1 != '0) && (n1[NMW] != sq_side.a_neg);
        dside4.neg2 = (n2 != '0) && (n2[NMW] != sq_side.a_neg);
      end
      default: begin
        num1 = '0;
      end
    endcase
  end

  logic                  s4_valid;
  logic [1:0][NUM_W-1:0] s4_dividend;
  logic [DEN_W-1:0]      s4_den;
  qrs_pkg::div_side_t    s4_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (en) begin
      s4_valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_dividend[0] <= {num1, {FRAC_BITS{1'b0}}};
      s4_dividend[1] <= {num2, {FRAC_BITS{1'b0}}};
      s4_den         <= den4;
      s4_side        <= dside4;
    end
  end

  // Shared-divisor quotient pipeline.
  logic                  dv_valid;
  logic [1:0][NUM_W-1:0] dv_quot;
  qrs_pkg::div_side_t    dv_side;

  qrs_div #(
    .NUM_W  (NUM_W),
    .DEN_W  (DEN_W),
    .SIDE_W ($bits(qrs_pkg::div_side_t))
  ) u_div (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (s4_valid),
    .in_dividend  (s4_dividend),
    .in_divisor   (s4_den),
    .in_side      (s4_side),
    .out_valid    (dv_valid),
    .out_quotient (dv_quot),
    .out_side     (dv_side)
  );

  // Apply the sign to a quotient magnitude and clip it to 32 bits.
  function automatic qrs_pkg::fix_t fx_sat(input logic neg, input logic [NUM_W-1:0] q);
    qrs_pkg::fix_t r;
    logic          big_pos;
    logic          big_neg;
    big_pos = |q[NUM_W-1:CW-1];
    big_neg = (|q[NUM_W-1:CW]) || (q[CW-1] && (|q[CW-2:0]));
    if (neg) begin
      r.sat = big_neg;
      r.val = big_neg ? {1'b1, {(CW-1){1'b0}}} : (CW'(0) - q[CW-1:0]);
    end else begin
      r.sat = big_pos;
      r.val = big_pos ? {1'b0, {(CW-1){1'b1}}} : q[CW-1:0];
    end
    return r;
  endfunction

  // Final result assembly from the quotients.
  qrs_pkg::fix_t r1, r2;
  logic [CW-1:0] fin_v1, fin_v2;
  logic          fin_sat;

  always_comb begin
    r1      = fx_sat(dv_side.neg1, dv_quot[0]);
    r2      = fx_sat(dv_side.neg2, dv_quot[1]);
    fin_v1  = '0;
    fin_v2  = '0;
    fin_sat = 1'b0;
    case (dv_side.code) inside
      qrs_pkg::CASE_LINEAR, qrs_pkg::CASE_DOUBLE: begin
        fin_v1  = r1.val;
        fin_sat = r1.sat;
      end
      qrs_pkg::CASE_TWO, qrs_pkg::CASE_COMPLEX: begin
        fin_v1  = r1.val;
        fin_v2  = r2.val;
        fin_sat = r1.sat || r2.sat;
      end
      default: begin
        fin_sat = 1'b0;
      end
    endcase
  end

  // Output register with a one-beat skid buffer behind it.
  logic          push;
  logic [2:0]    skid_code;
  logic [CW-1:0] skid_v1, skid_v2;
  logic          skid_sat;

  assign push = en && dv_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (skid_valid) begin
      if (result_ready) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
        case_code    <= skid_code;
        first_value  <= skid_v1;
        second_value <= skid_v2;
        saturated    <= skid_sat;
      end
    end else if (push) begin
      if (!result_valid || result_ready) begin
        result_valid <= 1'b1;
        case_code    <= dv_side.code;
        first_value  <= fin_v1;
        second_value <= fin_v2;
        saturated    <= fin_sat;
      end else begin
        skid_valid <= 1'b1;
        skid_code  <= dv_side.code;
        skid_v1    <= fin_v1;
        skid_v2    <= fin_v2;
        skid_sat   <= fin_sat;
      end
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/qrs_checker.sv =====
`default_nettype none

`include "quadratic_root_solver_top_macros.svh"

// Port-level checks on the result channel of the root solver.
module qrs_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        result_valid,
  input wire logic        result_ready,
  input wire logic [2:0]  case_code,
  input wire logic [31:0] first_value,
  input wire logic [31:0] second_value,
  input wire logic        saturated
);

  // No result beat is pending right after reset.
  `QRS_ASSERT_RST(a_reset_empty, !result_valid)

  // A stalled result beat keeps its values.
  `QRS_ASSERT_NXT(a_hold, result_valid && !result_ready,
                  result_valid && $stable(first_value) && $stable(second_value))

  // Degenerate equations (all reals or no root) report zero values and no clipping.
  `QRS_ASSERT_IMP(a_trivial_zero,
                  result_valid && (case_code == qrs_pkg::CASE_ALL ||
                                   case_code == qrs_pkg::CASE_NONE),
                  first_value == '0 && second_value == '0 && !saturated)

  // Single-root cases leave the second value at zero.
  `QRS_ASSERT_IMP(a_single_root,
                  result_valid && (case_code == qrs_pkg::CASE_LINEAR ||
                                   case_code == qrs_pkg::CASE_DOUBLE),
                  second_value == '0)

endmodule

bind quadratic_root_solver_top qrs_checker u_qrs_checker (.*);

`default_nettype wire
